/* rtl/fan_lvl_pkg.sv */
// shared types and constants for the fan level hysteresis controller
// used by fan_lvl_ctrl, fan_lvl_dp, the top level and the checker; no dependencies
package fan_lvl_pkg;

    localparam int MAX_LEVELS_DEF = 8;

    // port widths
    localparam int IN_FIELDS_W = 35;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE   = 2'd0,
        CFG_BIAS   = 2'd1,
        CFG_LEVELS = 2'd2
    } t_cfg_reg;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // reset values
    localparam logic [3:0] BASE_RST   = 4'd5;
    localparam logic [6:0] BIAS_RST   = 7'd5;
    localparam logic [3:0] LEVELS_RST = 4'd1;
    localparam logic [3:0] INTERVAL_RST = 4'd5;
    localparam logic [6:0] WD_RST     = 7'd30;

    localparam logic [6:0] WD_MULT     = 7'd6;
    localparam logic signed [8:0] JUMP_MIN = 9'sd2;
    localparam logic [3:0] FAST_INTERVAL = 4'd2;

    // x / 10 as (x * 419431) >> 22, exact for x below 699050
    localparam logic [37:0] DIV10_MUL   = 38'd419431;
    localparam int          DIV10_SHIFT = 22;
    // ceil(y / 10) as ((y + 9) * 205) >> 11, exact for sums below 1024
    localparam logic [9:0]  DEC_ROUND   = 10'd13;
    localparam logic [16:0] DEC_MUL     = 17'd205;
    localparam int          DEC_SHIFT   = 11;

    typedef struct packed {
        logic capture;
        logic load_entry;
        logic first;
        logic calc1;
        logic calc2;
        logic calc3;
        logic calc4;
        logic up_step;
        logic down_step;
        logic commit;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic started;
        logic hi_hit;
        logic lo_hit;
        logic at_top;
        logic at_zero;
    } t_dp_stat;

endpackage

/* rtl/fan_level_hysteresis_controller.sv */
// fan level controller: a load op goes via the emit state to the output register; a
// first sample runs init, downward walk, commit and emit; later ones four arithmetic
// steps, both table walks (one table entry per cycle, at most levels - 1 each), commit
// and emit. one transaction in flight; the next one is accepted while a result waits
// in the output register. synchronous active-low reset restores config defaults, clears
// the level index, bias and start flag; table contents stay undefined until loaded
module fan_level_hysteresis_controller #(
    parameter int MAX_LEVELS = fan_lvl_pkg::MAX_LEVELS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample / table load transactions
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] temperature, [10:8] entry_index, [18:11] entry_low,
    // [26:19] entry_high, [34:27] entry_fan_level, [39:35] zero
    input  logic [fan_lvl_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // [0] opcode
    input  logic                               s_axis_tuser,
    // result transactions
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] fan_level, [10:8] level_index, [14:11] next_interval, [15] zero
    output logic [fan_lvl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] write_fan, [1] watchdog_refresh
    output logic [fan_lvl_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    // register writes, always taken
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fan_lvl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fan_lvl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fan_lvl_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    logic [7:0] fan_level;
    logic [2:0] level_index;
    logic       write_fan;
    logic       watchdog;
    logic [3:0] next_interval;

    // sequencer: idle, first-sample init and downward walk or four arithmetic steps and
    // the two hysteresis walks, commit, then hand off to the output register (loads go direct)
    fan_lvl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_opcode    (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // datapath: table, bias multiply chain, watchdog and interval, output register
    fan_lvl_dp #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_fields        (s_axis_tdata[IN_FIELDS_W-1:0]),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fan_level     (fan_level),
        .o_level_index   (level_index),
        .o_write_fan     (write_fan),
        .o_watchdog      (watchdog),
        .o_next_interval (next_interval)
    );

    // pack the result, padding bit kept at zero
    assign m_axis_tdata = {1'b0, next_interval, level_index, fan_level};
    assign m_axis_tuser = {watchdog, write_fan};

    // config registers are plain flops, a write always lands
    assign o_cfg_ready = 1'b1;

endmodule

/* rtl/fan_lvl_ctrl.sv */
// sequencer for the fan level controller: steps one transaction through the datapath
// depends on fan_lvl_pkg
module fan_lvl_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_opcode,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output fan_lvl_pkg::t_dp_cmd  o_cmd,
    input  fan_lvl_pkg::t_dp_stat i_stat
);
    import fan_lvl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_CALC1,
        S_CALC2,
        S_CALC3,
        S_CALC4,
        S_UP,
        S_DOWN,
        S_FIN,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_opcode == OP_LOAD) begin
                        o_cmd.load_entry = 1'b1;
                        n_state          = S_EMIT;
                    end else if (i_stat.started) begin
                        n_state = S_CALC1;
                    end else begin
                        n_state = S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                o_cmd.first = 1'b1;
                n_state     = S_DOWN;
            end
            S_CALC1: begin
                o_cmd.calc1 = 1'b1;
                n_state     = S_CALC2;
            end
            S_CALC2: begin
                o_cmd.calc2 = 1'b1;
                n_state     = S_CALC3;
            end
            S_CALC3: begin
                o_cmd.calc3 = 1'b1;
                n_state     = S_CALC4;
            end
            S_CALC4: begin
                o_cmd.calc4 = 1'b1;
                n_state     = S_UP;
            end
            S_UP: begin
                o_cmd.up_step = 1'b1;
                if (!(i_stat.hi_hit && !i_stat.at_top)) begin
                    n_state = S_DOWN;
                end
            end
            S_DOWN: begin
                o_cmd.down_step = 1'b1;
                if (!(i_stat.lo_hit && !i_stat.at_zero)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.commit = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/fan_lvl_dp.sv */
// datapath of the fan level controller: config, level table, bias math, level walk
// depends on fan_lvl_pkg; driven by fan_lvl_ctrl
module fan_lvl_dp #(
    parameter int MAX_LEVELS = fan_lvl_pkg::MAX_LEVELS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fan_lvl_pkg::t_dp_cmd               i_cmd,
    output fan_lvl_pkg::t_dp_stat              o_stat,
    input  logic [fan_lvl_pkg::IN_FIELDS_W-1:0] i_fields,
    input  logic                               i_cfg_we,
    input  logic [fan_lvl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fan_lvl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic [7:0]                         o_fan_level,
    output logic [2:0]                         o_level_index,
    output logic                               o_write_fan,
    output logic                               o_watchdog,
    output logic [3:0]                         o_next_interval
);
    import fan_lvl_pkg::*;

    localparam int IW = $clog2(MAX_LEVELS);

    typedef struct packed {
        logic [7:0] lvl;
        logic [7:0] hi;
        logic [7:0] lo;
    } t_entry;

    // config
    logic [3:0] r_base;
    logic [6:0] r_bias_t;
    logic [3:0] r_levels;

    // persistent state
    t_entry          r_table [MAX_LEVELS];
    logic [IW-1:0]   r_ci;
    logic [7:0]      r_prev;
    logic [15:0]     r_bias;
    logic [3:0]      r_interval;
    logic [6:0]      r_wd_left;
    logic            r_started;

    // per transaction work registers
    logic [7:0]          r_temp;
    logic [IW-1:0]       r_idx;
    logic [3:0]          r_st;
    logic                r_wr;
    logic                r_wd;
    logic                r_jump;
    logic [11:0]         r_p1;
    logic [18:0]         r_p2;
    logic [5:0]          r_dec;
    logic signed [17:0]  r_btemp;

    // output register
    logic [7:0] r_out_level;
    logic [2:0] r_out_idx;
    logic       r_out_wr;
    logic       r_out_wd;
    logic [3:0] r_out_int;

    // input fields
    logic [7:0] in_temp;
    logic [2:0] in_eidx;
    logic [7:0] in_lo;
    logic [7:0] in_hi;
    logic [7:0] in_lvl;

    logic [3:0]         base_eff;
    logic [IW-1:0]      top;
    t_entry             entry;
    logic signed [7:0]  wd_sub;
    logic               wd_fire;
    logic [6:0]         wd_reload;
    logic signed [8:0]  diff;
    logic [8:0]         diff_m1;
    logic               jump;
    logic [3:0]         st_calc;
    logic [11:0]        p1;
    logic [18:0]        p2;
    logic [9:0]         dec_y;
    logic [16:0]        dec_prod;
    logic [37:0]        q_prod;
    logic signed [17:0] btemp;
    logic [15:0]        bias_dec;
    logic               load_ok;
    logic [31:0]        idx_wide;

    assign in_temp = i_fields[7:0];
    assign in_eidx = i_fields[10:8];
    assign in_lo   = i_fields[18:11];
    assign in_hi   = i_fields[26:19];
    assign in_lvl  = i_fields[34:27];

    assign base_eff = (r_base == 4'd0) ? 4'd1 : r_base;

    // top entry in use, levels saturated into 1..MAX_LEVELS
    always_comb begin
        if (r_levels == 4'd0) begin
            top = '0;
        end else if (32'(r_levels) > MAX_LEVELS) begin
            top = IW'(MAX_LEVELS - 1);
        end else begin
            top = IW'(r_levels - 4'd1);
        end
    end

    assign entry = r_table[r_idx];

    // watchdog countdown, can dip below zero after a base change
    assign wd_sub    = $signed({1'b0, r_wd_left}) - $signed({4'b0000, r_interval});
    assign wd_fire   = wd_sub <= $signed({4'b0000, base_eff});
    assign wd_reload = {3'b000, base_eff} * WD_MULT;

    assign diff    = $signed({r_temp[7], r_temp}) - $signed({r_prev[7], r_prev});
    assign diff_m1 = diff - 9'sd1;
    assign jump    = diff >= JUMP_MIN;

    always_comb begin
        if (jump) begin
            st_calc = (r_interval > FAST_INTERVAL) ? FAST_INTERVAL : r_interval;
        end else if (r_interval < base_eff) begin
            st_calc = r_interval + 4'd1;
        end else begin
            st_calc = r_interval;
        end
    end

    assign p1       = {8'b0, r_interval} * {4'b0, diff_m1[7:0]};
    assign p2       = {7'b0, r_p1} * {12'b0, r_bias_t};
    assign dec_y    = {1'b0, r_bias_t, 2'b00} + DEC_ROUND;
    assign dec_prod = {7'b0, dec_y} * DEC_MUL;
    // bias stays below 48388, so the quotient always fits 16 bits
    assign q_prod   = {19'b0, r_p2} * DIV10_MUL;
    assign btemp    = $signed({{10{r_temp[7]}}, r_temp}) + $signed({2'b00, r_bias});
    assign bias_dec = (r_bias > {10'b0, r_dec}) ? (r_bias - {10'b0, r_dec}) : 16'd0;

    assign load_ok  = 32'(in_eidx) < MAX_LEVELS;
    assign idx_wide = 32'(r_idx);

    assign o_stat.started = r_started;
    assign o_stat.hi_hit  = r_btemp >= $signed({{10{entry.hi[7]}}, entry.hi});
    assign o_stat.lo_hit  = r_btemp <= $signed({{10{entry.lo[7]}}, entry.lo});
    assign o_stat.at_top  = (r_idx == top);
    assign o_stat.at_zero = (r_idx == '0);

    // config and persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= BASE_RST;
            r_bias_t   <= BIAS_RST;
            r_levels   <= LEVELS_RST;
            r_ci       <= '0;
            r_prev     <= 8'd0;
            r_bias     <= 16'd0;
            r_interval <= INTERVAL_RST;
            r_wd_left  <= WD_RST;
            r_started  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_BASE:   r_base   <= i_cfg_data[3:0];
                    CFG_BIAS:   r_bias_t <= i_cfg_data;
                    CFG_LEVELS: r_levels <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_cmd.first) begin
                r_started <= 1'b1;
                r_wd_left <= wd_reload;
                r_bias    <= 16'd0;
            end
            if (i_cmd.calc1) begin
                r_wd_left <= wd_fire ? wd_reload : wd_sub[6:0];
            end
            if (i_cmd.calc3 && r_jump) begin
                r_bias <= q_prod[DIV10_SHIFT +: 16];
            end
            if (i_cmd.commit) begin
                r_ci       <= r_idx;
                r_interval <= r_st;
                r_prev     <= r_temp;
                if (r_bias != 16'd0) begin
                    r_bias <= bias_dec;
                end
            end
        end
    end

    // level table, undefined until loaded
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_entry && load_ok) begin
            r_table[IW'(in_eidx)] <= '{lvl: in_lvl, hi: in_hi, lo: in_lo};
        end
    end

    // work registers and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_temp <= in_temp;
            r_idx  <= r_ci;
            r_st   <= r_interval;
            r_wr   <= 1'b0;
            r_wd   <= 1'b0;
        end
        if (i_cmd.first) begin
            r_idx   <= top;
            r_btemp <= $signed({{10{r_temp[7]}}, r_temp});
            r_wr    <= 1'b1;
            r_wd    <= 1'b0;
            r_st    <= base_eff;
        end
        if (i_cmd.calc1) begin
            r_idx  <= (r_ci > top) ? top : r_ci;
            r_wr   <= wd_fire;
            r_wd   <= wd_fire;
            r_jump <= jump;
            r_p1   <= p1;
            r_st   <= st_calc;
        end
        if (i_cmd.calc2) begin
            r_p2  <= p2;
            r_dec <= dec_prod[DEC_SHIFT +: 6];
        end
        if (i_cmd.calc4) begin
            r_btemp <= btemp;
        end
        if (i_cmd.up_step && o_stat.hi_hit) begin
            r_wr <= 1'b1;
            if (!o_stat.at_top) begin
                r_idx <= r_idx + IW'(1);
            end
        end
        if (i_cmd.down_step && o_stat.lo_hit) begin
            r_wr <= 1'b1;
            r_st <= base_eff;
            if (!o_stat.at_zero) begin
                r_idx <= r_idx - IW'(1);
            end
        end
        if (i_cmd.load_out) begin
            r_out_level <= entry.lvl;
            r_out_idx   <= idx_wide[2:0];
            r_out_wr    <= r_wr;
            r_out_wd    <= r_wd;
            r_out_int   <= r_st;
        end
    end

    assign o_fan_level     = r_out_level;
    assign o_level_index   = r_out_idx;
    assign o_write_fan     = r_out_wr;
    assign o_watchdog      = r_out_wd;
    assign o_next_interval = r_out_int;

endmodule

/* rtl/fan_lvl_checker.sv */
// port-level checks for the fan level controller, bound to the top level
// depends on fan_lvl_pkg
module fan_lvl_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [fan_lvl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [fan_lvl_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import fan_lvl_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a result only leaves when taken
    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("result dropped without transaction");

    // one transaction at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    // a table load into an empty output stage answers via the emit state and the output register, no fan write
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_LOAD) && !m_axis_tvalid
            |=> ##1 m_axis_tvalid && (m_axis_tuser == '0))
        else $error("table load result late or flagged as write");

endmodule

bind fan_level_hysteresis_controller fan_lvl_checker u_fan_lvl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* test/fan_level_hysteresis_checker.sv */
// result checker for the fan level hysteresis controller testbench
// watches the sample, result and register channels, predicts every result and compares it
// depends on fan_lvl_pkg
`timescale 1ns / 100ps
module fan_level_hysteresis_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    input  logic [fan_lvl_pkg::IN_TDATA_W-1:0] i_s_tdata,
    input  logic                               i_s_tuser,
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [fan_lvl_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic [fan_lvl_pkg::OUT_TUSER_W-1:0] i_m_tuser,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [fan_lvl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fan_lvl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                 o_errors,
    output int                                 o_pending,
    output int                                 o_checked,
    output int                                 o_wd_seen
);
    import fan_lvl_pkg::*;

    localparam int NLEV = MAX_LEVELS_DEF;

    typedef struct packed {
        logic [7:0] fan_level;
        logic [2:0] level_index;
        logic [3:0] next_interval;
        logic       write_fan;
        logic       watchdog;
    } t_fan_result;

    // mirrored controller state
    int  lvl_lo  [NLEV];
    int  lvl_hi  [NLEV];
    int  lvl_fan [NLEV];
    int  cur_idx;
    int  prev_temp;
    int  jump_bias;
    int  sleep_now;
    int  wd_left;
    bit  running;
    int  base_reg;
    int  gain_reg;
    int  levels_reg;

    t_fan_result fan_results_due[$];
    int          mismatches;

    function automatic t_fan_result report(bit wr, bit wd);
        t_fan_result r;
        r.fan_level     = 8'(lvl_fan[cur_idx]);
        r.level_index   = 3'(cur_idx);
        r.next_interval = 4'(sleep_now);
        r.write_fan     = wr;
        r.watchdog      = wd;
        return r;
    endfunction

    function automatic t_fan_result load_entry(logic [IN_TDATA_W-1:0] d);
        int e;
        e = int'(d[10:8]);
        lvl_lo[e]  = int'($signed(d[18:11]));
        lvl_hi[e]  = int'($signed(d[26:19]));
        lvl_fan[e] = int'(d[34:27]);
        return report(1'b0, 1'b0);
    endfunction

    function automatic t_fan_result take_sample(int t);
        int base;
        int n;
        int st;
        int idx;
        int diff;
        int bt;
        int dec;
        bit wr;
        bit wd;
        base = (base_reg == 0) ? 1 : base_reg;
        n = (levels_reg == 0) ? 1 : ((levels_reg > NLEV) ? NLEV : levels_reg);
        wr = 1'b0;
        wd = 1'b0;
        if (!running) begin
            running   = 1'b1;
            sleep_now = base;
            wd_left   = int'(WD_MULT) * base;
            jump_bias = 0;
            idx = n - 1;
            while (idx > 0 && t <= lvl_lo[idx]) idx--;
            cur_idx   = idx;
            prev_temp = t;
            return report(1'b1, 1'b0);
        end
        st = sleep_now;
        wd_left -= st;
        if (wd_left <= base) begin
            wd = 1'b1;
            wr = 1'b1;
            wd_left = int'(WD_MULT) * base;
        end
        diff = t - prev_temp;
        if (diff >= int'(JUMP_MIN)) begin
            jump_bias = st * (diff - 1) * gain_reg / 10;
            if (jump_bias > 65535) jump_bias = 65535;
            if (st > int'(FAST_INTERVAL)) st = int'(FAST_INTERVAL);
        end else if (st < base) begin
            st++;
        end
        bt = t + jump_bias;
        idx = (cur_idx >= n) ? n - 1 : cur_idx;
        if (bt >= lvl_hi[idx]) begin
            while (bt >= lvl_hi[idx] && idx < n - 1) idx++;
            wr = 1'b1;
        end
        if (bt <= lvl_lo[idx]) begin
            while (bt <= lvl_lo[idx] && idx > 0) idx--;
            wr = 1'b1;
            st = base;
        end
        cur_idx = idx;
        if (jump_bias != 0) begin
            dec = ((gain_reg + 1) * 4 + 9) / 10;
            jump_bias = (jump_bias > dec) ? jump_bias - dec : 0;
        end
        sleep_now = st & 15;
        prev_temp = t;
        return report(wr, wd);
    endfunction

    always @(posedge i_clk) begin : watch
        t_fan_result got;
        t_fan_result want;
        if (!i_rst_n) begin
            base_reg   = int'(BASE_RST);
            gain_reg   = int'(BIAS_RST);
            levels_reg = int'(LEVELS_RST);
            cur_idx    = 0;
            prev_temp  = 0;
            jump_bias  = 0;
            sleep_now  = int'(INTERVAL_RST);
            wd_left    = int'(WD_RST);
            running    = 1'b0;
            fan_results_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.fan_level     = i_m_tdata[7:0];
                got.level_index   = i_m_tdata[10:8];
                got.next_interval = i_m_tdata[14:11];
                got.write_fan     = i_m_tuser[0];
                got.watchdog      = i_m_tuser[1];
                o_checked++;
                if (got.watchdog === 1'b1) o_wd_seen++;
                if (fan_results_due.size() == 0) begin
                    o_errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing outstanding: fan %0d idx %0d",
                                 $realtime, got.fan_level, got.level_index);
                end else begin
                    want = fan_results_due.pop_front();
                    if (got.fan_level !== want.fan_level
                            || got.level_index !== want.level_index
                            || got.next_interval !== want.next_interval
                            || got.write_fan !== want.write_fan
                            || got.watchdog !== want.watchdog) begin
                        o_errors++;
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: result mismatch, expected fan %0d idx %0d ivl %0d wr %0b wd %0b",
                                     $realtime, want.fan_level, want.level_index,
                                     want.next_interval, want.write_fan, want.watchdog);
                            $display("    got fan %0d idx %0d ivl %0d wr %0b wd %0b",
                                     got.fan_level, got.level_index, got.next_interval,
                                     got.write_fan, got.watchdog);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BASE:   base_reg   = int'(i_cfg_data[3:0]);
                    CFG_BIAS:   gain_reg   = int'(i_cfg_data);
                    CFG_LEVELS: levels_reg = int'(i_cfg_data[3:0]);
                    default:    ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == OP_LOAD)
                    fan_results_due.push_back(load_entry(i_s_tdata));
                else
                    fan_results_due.push_back(take_sample(int'($signed(i_s_tdata[7:0]))));
            end
        end
        o_pending = fan_results_due.size();
    end

endmodule

/* test/fan_level_hysteresis_controller_tb.sv */
// top of the fan level hysteresis controller testbench: clock, reset and stimulus
// instantiates the controller and fan_level_hysteresis_checker; depends on fan_lvl_pkg
`timescale 1ns / 100ps
module fan_level_hysteresis_controller_tb;
    import fan_lvl_pkg::*;

    localparam int ITEMS_PER_PHASE = 150;
    localparam int NUM_PHASES      = 10;
    // longest sample path is the four arithmetic steps plus both full table walks, so this is plenty
    localparam int SETTLE_CYCLES   = 40;
    // slowest correct run is well under 400 us
    localparam int TIMEOUT_NS      = 2_000_000;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                    s_axis_tuser  = OP_SAMPLE;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [OUT_TUSER_W-1:0]  m_axis_tuser;
    logic                    i_cfg_valid   = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data    = '0;

    int fail_count;
    int pending;
    int checked;
    int wd_count;

    // idle bursts on the sample side and stalls on the result side
    bit gaps_on;
    bit stalls_on;
    int stall_left;

    // temperature random walk, kept around the span of the loaded table
    int walk_t;
    int walk_lo;
    int walk_hi;

    int n_samples;
    int n_loads;
    int n_writes;

    // opening sequence: first pick, small drift, jump with bias, extremes both ways
    int warmup_temps[$] = '{50, 51, 60, 61, 61, -128, -128, 0, 30, 33, 45, 127, 127};

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    fan_level_hysteresis_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    fan_level_hysteresis_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tuser   (m_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_wd_seen   (wd_count)
    );

    // result side back-pressure: random stall bursts while enabled
    always @(negedge i_clk) begin
        if (!stalls_on) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic int clamp8(int v);
        return (v < -128) ? -128 : ((v > 127) ? 127 : v);
    endfunction

    function automatic int rand_range(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // one transaction on the sample channel, with an optional idle burst ahead of it
    task automatic send_item(logic op, logic [IN_TDATA_W-1:0] d);
        int gap;
        gap = (gaps_on && $urandom_range(0, 3) == 0) ? rand_range(1, 3) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (op == OP_LOAD) n_loads++;
        else n_samples++;
    endtask

    // the entry fields are don't-care for a sample, so they carry noise
    task automatic send_sample(int t);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[7:0]  = 8'(t);
        d[34:8] = 27'($urandom);
        send_item(OP_SAMPLE, d);
    endtask

    task automatic send_entry(int e, int lo, int hi, int fan);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[7:0]   = 8'($urandom);
        d[10:8]  = 3'(e);
        d[18:11] = 8'(lo);
        d[26:19] = 8'(hi);
        d[34:27] = 8'(fan);
        send_item(OP_LOAD, d);
    endtask

    // hold the sender until every outstanding result has come back
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg r, int v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= 7'(v);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_writes++;
    endtask

    // register writes only go in while nothing is in flight
    task automatic set_config(int base, int gain, int levels);
        wait_idle();
        write_reg(CFG_BASE, base);
        write_reg(CFG_BIAS, gain);
        write_reg(CFG_LEVELS, levels);
    endtask

    // ascending table with overlapping thresholds so hysteresis has room to work;
    // now and then an entry is scrambled to break the ordering
    task automatic load_ramp_table();
        int start;
        int step;
        int c;
        start = rand_range(-128, 20);
        step  = rand_range(3, 14);
        for (int i = 0; i < MAX_LEVELS_DEF; i++) begin
            c = start + i * step;
            if ($urandom_range(0, 9) == 0)
                send_entry(i, rand_range(-128, 127), rand_range(-128, 127), rand_range(0, 255));
            else
                send_entry(i, clamp8(c - rand_range(0, 3)), clamp8(c + step + rand_range(0, 3)),
                           rand_range(0, 255));
        end
        walk_lo = clamp8(start - 8);
        walk_hi = clamp8(start + MAX_LEVELS_DEF * step + 8);
        walk_t  = (walk_lo + walk_hi) / 2;
    endtask

    // mostly drift, some upward jumps that build bias, some drops, rare wild values
    task automatic random_sample();
        int pick;
        int t;
        pick = $urandom_range(0, 19);
        if (pick < 12)      t = walk_t + rand_range(-3, 3);
        else if (pick < 17) t = walk_t + rand_range(2, 25);
        else if (pick < 19) t = walk_t - rand_range(2, 25);
        else                t = rand_range(-128, 127);
        t = clamp8(t);
        send_sample(t);
        walk_t = (t < walk_lo) ? walk_lo : ((t > walk_hi) ? walk_hi : t);
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int base;
        int gain;
        int levels;
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: full table first so no sample ever reads an unloaded entry
        set_config(3, 10, 8);
        for (int i = 0; i < MAX_LEVELS_DEF; i++)
            send_entry(i, (i == 0) ? -128 : 10 * i + 10, (i == 7) ? 127 : 10 * i + 25,
                       (i == 7) ? 255 : i);
        walk_lo = -20;
        walk_hi = 100;
        walk_t  = 40;
        // first sample does the top-down pick, the rest walk up and down,
        // with one table load in the middle to see the state report
        foreach (warmup_temps[i]) begin
            if (i == 9) send_entry(3, 40, 55, 3);
            send_sample(warmup_temps[i]);
        end
        // index sits at the top; shrinking the table forces the clamp
        wait_idle();
        write_reg(CFG_LEVELS, 3);
        send_sample(100);

        // random part: each phase gets its own settings, extremes first
        for (int p = 0; p < NUM_PHASES; p++) begin
            // last phase runs flat out on both sides
            gaps_on   = (p < NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            stalls_on = (p < NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            case (p)
                0: begin base = 15; gain = 127; levels = 15; end
                1: begin base = 0;  gain = 0;   levels = 0;  end
                2: begin base = 1;  gain = 100; levels = 8;  end
                default: begin
                    base   = rand_range(1, 15);
                    gain   = rand_range(0, 100);
                    levels = rand_range(1, 8);
                end
            endcase
            set_config(base, gain, levels);
            if (p == 0 || $urandom_range(0, 1) == 1) load_ramp_table();
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if ($urandom_range(0, 99) < 3) begin
                    send_entry(rand_range(0, 7), rand_range(-128, 127), rand_range(-128, 127),
                               rand_range(0, 255));
                end else if ($urandom_range(0, 99) == 0) begin
                    // let the pipe run dry before the next sample
                    wait_idle();
                    random_sample();
                end else begin
                    random_sample();
                end
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("ran %0d samples and %0d table loads through %0d setting phases (%0d reg writes)",
                 n_samples, n_loads, NUM_PHASES + 1, n_writes);
        $display("%0d results compared, %0d of them watchdog rewrites", checked, wd_count);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
